// File: sv/i2c_master_bit_engine_macros.svh
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Shorthand for clocked assertions; each one expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define I2CMB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c master bit engine check failed");

// Consequent must hold in the cycle after the antecedent.
`define I2CMB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c master bit engine check failed");

`endif

// File: sv/i2cmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Word types, command codes, bus phases and register indexes.
// ----------------------------------------------------------------------------
package i2cmb_pkg;

    localparam logic [2:0] FUNC_START   = 3'd0;
    localparam logic [2:0] FUNC_STOP    = 3'd1;
    localparam logic [2:0] FUNC_WRITE   = 3'd2;
    localparam logic [2:0] FUNC_READ    = 3'd3;
    localparam logic [2:0] FUNC_RECOVER = 3'd4;

    localparam logic CFG_HALF_PERIOD   = 1'b0;
    localparam logic CFG_STRETCH_LIMIT = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RESET   = 16'd5;
    localparam logic [15:0] STRETCH_LIMIT_RESET = 16'd1000;

    localparam logic [3:0] RECOVER_PULSES = 4'd9;
    localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] func;
        logic [7:0] wr_data;
        logic       send_ack;
        logic       sda_in;
        logic       scl_in;
    } in_t;

    typedef struct packed {
        logic       sda_drive_low;
        logic       scl_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_data;
        logic       got_ack;
        logic       stretch_timeout;
    } out_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ,
        CMD_RECOVER
    } cmd_e;

    typedef struct packed {
        cmd_e       cmd;
        logic [7:0] wr_data;
        logic       send_ack;
        logic       sda_in;
        logic       scl_in;
    } cls_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_S1, PH_S2, PH_S3, PH_S4,
        PH_P1, PH_P2, PH_P3,
        PH_WD, PH_WH, PH_WL, PH_WAR, PH_WAH, PH_WAL,
        PH_RL, PH_RH, PH_RAL, PH_RAH, PH_RAE,
        PH_VS, PH_VL, PH_VH
    } phase_e;

endpackage

// File: sv/i2cmb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine word queue
// Small register queue; the head word is shown while empty is low.
// ----------------------------------------------------------------------------
module i2cmb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/i2cmb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine front end
// Accepts tick words, decodes the command field and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cmb_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  i2cmb_pkg::in_t   item,
    input  logic             take,
    output logic             empty,
    output i2cmb_pkg::cls_t  cls
);
    import i2cmb_pkg::*;

    cls_t cls_in;

    always_comb
    begin
        cls_in.wr_data  = item.wr_data;
        cls_in.send_ack = item.send_ack;
        cls_in.sda_in   = item.sda_in;
        cls_in.scl_in   = item.scl_in;
        cls_in.cmd      = CMD_NONE;
        // drop the command field unless a known command is offered
        if (item.cmd_valid)
        begin
            case (item.func)
                FUNC_START:   cls_in.cmd = CMD_START;
                FUNC_STOP:    cls_in.cmd = CMD_STOP;
                FUNC_WRITE:   cls_in.cmd = CMD_WRITE;
                FUNC_READ:    cls_in.cmd = CMD_READ;
                FUNC_RECOVER: cls_in.cmd = CMD_RECOVER;
                default:      cls_in.cmd = CMD_NONE;
            endcase
        end
    end

    i2cmb_fifo #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_in),
        .full    (full),
        .rd_en   (take),
        .rd_data (cls),
        .empty   (empty)
    );

endmodule

// File: sv/i2cmb_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine bus sequencer
// Steps the bus phase machine by one tick for each word taken.
// ----------------------------------------------------------------------------
module i2cmb_engine #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  i2cmb_pkg::cls_t  cls,
    input  logic [15:0]      half_period,
    input  logic [15:0]      stretch_limit,
    output i2cmb_pkg::out_t  res
);
    import i2cmb_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    phase_e                 phase_reg, phase_next;
    logic [3:0]             bit_count_reg, bit_count_next;
    logic [COUNT_WIDTH-1:0] delay_reg, delay_next;
    logic [COUNT_WIDTH-1:0] stretch_reg, stretch_next;
    logic [7:0]             shift_reg, shift_next;
    logic [3:0]             pulse_reg, pulse_next;
    logic                   sda_low_reg, sda_low_next;
    logic                   scl_low_reg, scl_low_next;
    logic                   ack_flag_reg, ack_flag_next;
    logic                   clk_wait_reg, clk_wait_next;
    logic                   ack_out_reg, ack_out_next;
    logic [7:0]             rx_reg, rx_next;
    logic                   timeout_reg, timeout_next;

    logic                   hold;
    logic                   done;
    logic                   enter_en;
    phase_e                 enter_ph;
    phase_e                 fin_ph;
    logic [COUNT_WIDTH-1:0] delay_inc;
    logic [COUNT_WIDTH-1:0] stretch_inc;
    logic [15:0]            hp;
    logic [3:0]             bit_inc;
    logic [3:0]             pulse_inc;

    assign hp        = (half_period == '0) ? 16'd1 : half_period;
    assign delay_inc = (delay_reg == '1) ? delay_reg : delay_reg + 1'b1;
    assign stretch_inc = (stretch_reg == '1) ? stretch_reg : stretch_reg + 1'b1;
    assign bit_inc   = bit_count_reg + 1'b1;
    assign pulse_inc = pulse_reg + 1'b1;

    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        delay_next     = delay_reg;
        stretch_next   = stretch_reg;
        shift_next     = shift_reg;
        pulse_next     = pulse_reg;
        sda_low_next   = sda_low_reg;
        scl_low_next   = scl_low_reg;
        ack_flag_next  = ack_flag_reg;
        clk_wait_next  = clk_wait_reg;
        ack_out_next   = ack_out_reg;
        rx_next        = rx_reg;
        timeout_next   = timeout_reg;
        hold           = 1'b1;
        done           = 1'b0;
        enter_en       = 1'b0;
        enter_ph       = PH_IDLE;
        fin_ph         = PH_IDLE;

        if (phase_reg == PH_IDLE)
        begin
            if (cls.cmd != CMD_NONE)
            begin
                timeout_next = 1'b0;
                enter_en     = 1'b1;
            end
            case (cls.cmd)
                CMD_START:   enter_ph = PH_S1;
                CMD_STOP:    enter_ph = PH_P1;
                CMD_WRITE:
                begin
                    shift_next     = cls.wr_data;
                    bit_count_next = '0;
                    enter_ph       = PH_WD;
                end
                CMD_READ:
                begin
                    shift_next     = '0;
                    bit_count_next = '0;
                    ack_out_next   = cls.send_ack;
                    enter_ph       = PH_RL;
                end
                CMD_RECOVER:
                begin
                    pulse_next = '0;
                    enter_ph   = PH_VS;
                end
                default:     enter_ph = PH_IDLE;
            endcase
        end
        else
        begin
            // wait for SCL to read high; a slave may stretch the clock
            if (clk_wait_reg)
            begin
                if (cls.scl_in)
                begin
                    clk_wait_next = 1'b0;
                end
                else
                begin
                    stretch_next = stretch_inc;
                    if (CMP_W'(stretch_inc) >= CMP_W'(stretch_limit))
                    begin
                        timeout_next  = 1'b1;
                        clk_wait_next = 1'b0;
                    end
                    hold = 1'b0;
                end
            end
            if (hold)
            begin
                delay_next = delay_inc;
                if (CMP_W'(delay_inc) >= CMP_W'(hp))
                begin
                    case (phase_reg)
                        PH_S1: fin_ph = PH_S2;
                        PH_S2: fin_ph = PH_S3;
                        PH_S3: fin_ph = PH_S4;
                        PH_P1: fin_ph = PH_P2;
                        PH_P2: fin_ph = PH_P3;
                        PH_WD: fin_ph = PH_WH;
                        PH_WH: fin_ph = PH_WL;
                        PH_WL:
                        begin
                            shift_next     = {shift_reg[6:0], 1'b0};
                            bit_count_next = bit_inc;
                            fin_ph = (bit_inc >= BITS_PER_BYTE) ? PH_WAR : PH_WD;
                        end
                        PH_WAR: fin_ph = PH_WAH;
                        PH_WAH:
                        begin
                            ack_flag_next = !cls.sda_in;
                            fin_ph        = PH_WAL;
                        end
                        PH_RL: fin_ph = PH_RH;
                        PH_RH:
                        begin
                            shift_next     = {shift_reg[6:0], cls.sda_in};
                            bit_count_next = bit_inc;
                            fin_ph = (bit_inc >= BITS_PER_BYTE) ? PH_RAL : PH_RL;
                        end
                        PH_RAL: fin_ph = PH_RAH;
                        PH_RAH: fin_ph = PH_RAE;
                        PH_RAE:
                        begin
                            sda_low_next = 1'b0;
                            rx_next      = shift_reg;
                            fin_ph       = PH_IDLE;
                        end
                        PH_VS:
                        begin
                            pulse_next = '0;
                            fin_ph     = cls.sda_in ? PH_IDLE : PH_VL;
                        end
                        PH_VL: fin_ph = PH_VH;
                        PH_VH:
                        begin
                            pulse_next = pulse_inc;
                            fin_ph = (cls.sda_in || pulse_inc >= RECOVER_PULSES) ? PH_P1
                                                                                  : PH_VL;
                        end
                        default: fin_ph = PH_IDLE;
                    endcase
                    if (fin_ph == PH_IDLE)
                    begin
                        phase_next    = PH_IDLE;
                        delay_next    = '0;
                        stretch_next  = '0;
                        clk_wait_next = 1'b0;
                        done          = 1'b1;
                    end
                    else
                    begin
                        enter_en = 1'b1;
                        enter_ph = fin_ph;
                    end
                end
            end
        end

        // set the pins of the phase being entered
        if (enter_en)
        begin
            phase_next    = enter_ph;
            delay_next    = '0;
            stretch_next  = '0;
            clk_wait_next = 1'b0;
            case (enter_ph)
                PH_S1, PH_P3, PH_WAR: sda_low_next = 1'b0;
                PH_S3, PH_P1:         sda_low_next = 1'b1;
                PH_S4, PH_WL, PH_WAL, PH_RAE, PH_VL: scl_low_next = 1'b1;
                PH_WD:                sda_low_next = !shift_next[7];
                PH_RL:
                begin
                    scl_low_next = 1'b1;
                    sda_low_next = 1'b0;
                end
                PH_RAL:
                begin
                    scl_low_next = 1'b1;
                    sda_low_next = ack_out_next;
                end
                PH_VS:
                begin
                    sda_low_next  = 1'b0;
                    scl_low_next  = 1'b0;
                    clk_wait_next = 1'b1;
                end
                PH_S2, PH_P2, PH_WH, PH_WAH, PH_RH, PH_RAH, PH_VH:
                begin
                    scl_low_next  = 1'b0;
                    clk_wait_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res.sda_drive_low   = sda_low_next;
        res.scl_drive_low   = scl_low_next;
        res.busy_res        = (phase_next != PH_IDLE);
        res.done_res        = done;
        res.rx_data         = rx_next;
        res.got_ack         = ack_flag_next;
        res.stretch_timeout = timeout_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            delay_reg     <= '0;
            stretch_reg   <= '0;
            shift_reg     <= '0;
            pulse_reg     <= '0;
            sda_low_reg   <= 1'b0;
            scl_low_reg   <= 1'b0;
            ack_flag_reg  <= 1'b0;
            clk_wait_reg  <= 1'b0;
            ack_out_reg   <= 1'b0;
            rx_reg        <= '0;
            timeout_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            delay_reg     <= delay_next;
            stretch_reg   <= stretch_next;
            shift_reg     <= shift_next;
            pulse_reg     <= pulse_next;
            sda_low_reg   <= sda_low_next;
            scl_low_reg   <= scl_low_next;
            ack_flag_reg  <= ack_flag_next;
            clk_wait_reg  <= clk_wait_next;
            ack_out_reg   <= ack_out_next;
            rx_reg        <= rx_next;
            timeout_reg   <= timeout_next;
        end
    end

endmodule

// File: sv/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine
// Runs START, STOP, byte write, byte read and bus recovery one tick per word.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------
//   tick in  | push / full           | item   (in_t)
//   result   | empty / pop           | result (out_t)
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data (16 bit)
//
// One tick word is taken and one result word produced per clock while ticks wait and the result queue has room.
// A tick passes the input queue, then the engine, and its result is registered in the result queue.
// The engine steps its phase machine once per word and stalls only while the
// result queue is full; full rises when the input queue holds QUEUE_DEPTH words.
// After reset the block is ready at once; config writes are always taken.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
    parameter int COUNT_WIDTH = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  i2cmb_pkg::in_t   item,
    output logic             empty,
    input  logic             pop,
    output i2cmb_pkg::out_t  result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data
);
    import i2cmb_pkg::*;

    logic [15:0] half_period_reg;
    logic [15:0] stretch_limit_reg;
    logic        mid_empty;
    logic        res_full;
    logic        take;
    cls_t        cls;
    out_t        res;

    assign cfg_ready = 1'b1;
    assign take      = !mid_empty && !res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg   <= HALF_PERIOD_RESET;
            stretch_limit_reg <= STRETCH_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD:   half_period_reg   <= cfg_data;
                CFG_STRETCH_LIMIT: stretch_limit_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    i2cmb_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .take  (take),
        .empty (mid_empty),
        .cls   (cls)
    );

    i2cmb_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .cls           (cls),
        .half_period   (half_period_reg),
        .stretch_limit (stretch_limit_reg),
        .res           (res)
    );

    i2cmb_fifo #(
        .WIDTH ($bits(out_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// File: sv/i2cmb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine port checker
// Tracks words in flight and checks the result channel against it.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_macros.svh"

module i2cmb_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            push,
    input logic            full,
    input logic            empty,
    input logic            pop,
    input i2cmb_pkg::out_t result
);
    import i2cmb_pkg::*;

    logic [7:0] outstanding_reg, outstanding_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    always_comb
    begin
        case ({in_acc, out_acc})
            2'b10:   outstanding_next = outstanding_reg + 1'b1;
            2'b01:   outstanding_next = outstanding_reg - 1'b1;
            default: outstanding_next = outstanding_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // no result without a tick that caused it
    `I2CMB_ASSERT_NOW(a_no_invented, !empty, outstanding_reg != 8'd0)
    // with nothing in flight the result side stays empty
    `I2CMB_ASSERT_NOW(a_idle_empty, outstanding_reg == 8'd0, empty)
    // a completing command has left the busy state
    `I2CMB_ASSERT_NOW(a_done_not_busy, !empty && result.done_res, !result.busy_res)
    // hold a waiting result until popped
    `I2CMB_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result))

endmodule

bind i2c_master_bit_engine i2cmb_checker u_checker (.*);

// File: tb/sv/i2c_master_bit_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Watches the tick, result and config channels and predicts the pin and
// status word of every accepted tick. Each popped result word is compared
// field by field with the oldest prediction, and a running failure count
// is handed back to the testbench top.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  i2cmb_pkg::in_t   item,
    input  logic             empty,
    input  logic             pop,
    input  i2cmb_pkg::out_t  result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    output int               pending,
    output int               fails
);
    import i2cmb_pkg::*;

    // predicted engine state
    phase_e      ph;
    logic [3:0]  bit_n;
    logic [15:0] hold_cnt;
    logic [15:0] stretch_cnt;
    logic [7:0]  shreg;
    logic [3:0]  pulse_n;
    logic        drv_sda;
    logic        drv_scl;
    logic        ack_seen;
    logic        wait_scl;
    logic        ack_reply;
    logic [7:0]  rx_byte_q;
    logic        tmo_flag;
    logic [15:0] half_per;
    logic [15:0] stretch_lim;

    out_t        pin_words_due[$];
    out_t        want;
    int          errs = 0;

    function void reset_engine();
        ph          = PH_IDLE;
        bit_n       = '0;
        hold_cnt    = '0;
        stretch_cnt = '0;
        shreg       = '0;
        pulse_n     = '0;
        drv_sda     = 1'b0;
        drv_scl     = 1'b0;
        ack_seen    = 1'b0;
        wait_scl    = 1'b0;
        ack_reply   = 1'b0;
        rx_byte_q   = '0;
        tmo_flag    = 1'b0;
        half_per    = HALF_PERIOD_RESET;
        stretch_lim = STRETCH_LIMIT_RESET;
    endfunction

    // Set the pins of a phase on the tick it is entered.
    function void enter_phase(phase_e p);
        ph          = p;
        hold_cnt    = '0;
        stretch_cnt = '0;
        wait_scl    = 1'b0;
        case (p)
            PH_S1, PH_P3, PH_WAR: drv_sda = 1'b0;
            PH_S3, PH_P1:         drv_sda = 1'b1;
            PH_S4, PH_WL, PH_WAL, PH_RAE, PH_VL: drv_scl = 1'b1;
            PH_WD: drv_sda = ~shreg[7];
            PH_RL:
            begin
                drv_scl = 1'b1;
                drv_sda = 1'b0;
            end
            PH_RAL:
            begin
                drv_scl = 1'b1;
                drv_sda = ack_reply;
            end
            PH_VS:
            begin
                drv_sda  = 1'b0;
                drv_scl  = 1'b0;
                wait_scl = 1'b1;
            end
            PH_S2, PH_P2, PH_WH, PH_WAH, PH_RH, PH_RAH, PH_VH:
            begin
                drv_scl  = 1'b0;
                wait_scl = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Close the current phase and pick the next one; idle means done.
    function phase_e close_phase(logic sda);
        phase_e nxt;
        nxt = PH_IDLE;
        case (ph)
            PH_S1:  nxt = PH_S2;
            PH_S2:  nxt = PH_S3;
            PH_S3:  nxt = PH_S4;
            PH_P1:  nxt = PH_P2;
            PH_P2:  nxt = PH_P3;
            PH_WD:  nxt = PH_WH;
            PH_WH:  nxt = PH_WL;
            PH_WL:
            begin
                shreg = shreg << 1;
                bit_n = bit_n + 4'd1;
                nxt   = (bit_n >= BITS_PER_BYTE) ? PH_WAR : PH_WD;
            end
            PH_WAR: nxt = PH_WAH;
            PH_WAH:
            begin
                ack_seen = ~sda;
                nxt      = PH_WAL;
            end
            PH_RL:  nxt = PH_RH;
            PH_RH:
            begin
                shreg = {shreg[6:0], sda};
                bit_n = bit_n + 4'd1;
                nxt   = (bit_n >= BITS_PER_BYTE) ? PH_RAL : PH_RL;
            end
            PH_RAL: nxt = PH_RAH;
            PH_RAH: nxt = PH_RAE;
            PH_RAE:
            begin
                drv_sda   = 1'b0;
                rx_byte_q = shreg;
                nxt       = PH_IDLE;
            end
            PH_VS:
            begin
                pulse_n = '0;
                nxt     = sda ? PH_IDLE : PH_VL;
            end
            PH_VL:  nxt = PH_VH;
            PH_VH:
            begin
                pulse_n = pulse_n + 4'd1;
                nxt     = (sda || pulse_n >= RECOVER_PULSES) ? PH_P1 : PH_VL;
            end
            default: nxt = PH_IDLE;
        endcase
        return nxt;
    endfunction

    // Advance the engine by one tick and return the word it shows after it.
    function out_t engine_tick(in_t w);
        out_t        r;
        logic        advance;
        logic        fin;
        logic [15:0] hp;
        phase_e      nxt;
        fin = 1'b0;
        if (ph == PH_IDLE) begin
            if (w.cmd_valid && w.func <= FUNC_RECOVER) begin
                tmo_flag = 1'b0;
                case (w.func)
                    FUNC_START: enter_phase(PH_S1);
                    FUNC_STOP:  enter_phase(PH_P1);
                    FUNC_WRITE:
                    begin
                        shreg = w.wr_data;
                        bit_n = '0;
                        enter_phase(PH_WD);
                    end
                    FUNC_READ:
                    begin
                        shreg     = '0;
                        bit_n     = '0;
                        ack_reply = w.send_ack;
                        enter_phase(PH_RL);
                    end
                    default:
                    begin
                        pulse_n = '0;
                        enter_phase(PH_VS);
                    end
                endcase
            end
        end else begin
            advance = 1'b1;
            // a released SCL must read high before the hold runs
            if (wait_scl) begin
                if (w.scl_in) begin
                    wait_scl = 1'b0;
                end else begin
                    if (stretch_cnt != '1)
                        stretch_cnt = stretch_cnt + 16'd1;
                    if (stretch_cnt >= stretch_lim) begin
                        tmo_flag = 1'b1;
                        wait_scl = 1'b0;
                    end
                    advance = 1'b0;
                end
            end
            if (advance) begin
                hp = (half_per == '0) ? 16'd1 : half_per;
                if (hold_cnt != '1)
                    hold_cnt = hold_cnt + 16'd1;
                if (hold_cnt >= hp) begin
                    nxt = close_phase(w.sda_in);
                    if (nxt == PH_IDLE) begin
                        ph          = PH_IDLE;
                        hold_cnt    = '0;
                        stretch_cnt = '0;
                        wait_scl    = 1'b0;
                        fin         = 1'b1;
                    end else begin
                        enter_phase(nxt);
                    end
                end
            end
        end
        r.sda_drive_low   = drv_sda;
        r.scl_drive_low   = drv_scl;
        r.busy_res        = (ph != PH_IDLE);
        r.done_res        = fin;
        r.rx_data         = rx_byte_q;
        r.got_ack         = ack_seen;
        r.stretch_timeout = tmo_flag;
        return r;
    endfunction

    task check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            errs++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            reset_engine();
            pin_words_due.delete();
            pending <= 0;
            fails   <= errs;
        end else begin
            if (pop && !empty) begin
                if (pin_words_due.size() == 0) begin
                    errs++;
                    $display("%0t: result word with nothing expected, expected none actual %h",
                             $time, result);
                end else begin
                    want = pin_words_due.pop_front();
                    check_field("sda_drive_low", want.sda_drive_low, result.sda_drive_low);
                    check_field("scl_drive_low", want.scl_drive_low, result.scl_drive_low);
                    check_field("busy_res", want.busy_res, result.busy_res);
                    check_field("done_res", want.done_res, result.done_res);
                    check_field("rx_data", want.rx_data, result.rx_data);
                    check_field("got_ack", want.got_ack, result.got_ack);
                    check_field("stretch_timeout", want.stretch_timeout,
                                result.stretch_timeout);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_HALF_PERIOD)
                    half_per = cfg_data;
                else
                    stretch_lim = cfg_data;
            end
            if (push && !full)
                pin_words_due.push_back(engine_tick(item));
            pending <= pin_words_due.size();
            fails   <= errs;
        end
    end

endmodule

// File: tb/sv/i2c_master_bit_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Feeds bus ticks with sampled SDA/SCL levels and commands: a directed pass
// over every command and corner case, then random segments under several
// timing settings with random idling, a long receiver hold-off and drains.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
    import i2cmb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 80;
    localparam int NUM_SEGS       = 8;
    localparam int MODE_FREE      = 0;
    localparam int MODE_HOLD      = 1;
    localparam int MODE_STEADY    = 2;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_t         item;
    logic        empty;
    logic        pop;
    out_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          pending;
    int          fails;

    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          hold_reqs = 0;
    int          holds_done = 0;
    int          idle_cycles = 0;

    // random segments: timing setting, line biases, command rate, length, mode
    int seg_hp   [NUM_SEGS] = '{1, 2, 0, 1, 65535, 3, 1, 5};
    int seg_sl   [NUM_SEGS] = '{65535, 3, 0, 1, 65535, 20, 2, 1000};
    int seg_sda  [NUM_SEGS] = '{50, 50, 50, 15, 50, 50, 85, 50};
    int seg_scl  [NUM_SEGS] = '{95, 70, 80, 90, 50, 85, 75, 98};
    int seg_cmd  [NUM_SEGS] = '{20, 20, 20, 25, 50, 20, 20, 20};
    int seg_len  [NUM_SEGS] = '{180, 200, 150, 180, 60, 180, 150, 145};
    int seg_mode [NUM_SEGS] = '{MODE_FREE, MODE_HOLD, MODE_FREE, MODE_STEADY,
                                MODE_FREE, MODE_FREE, MODE_FREE, MODE_FREE};

    i2c_master_bit_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    i2c_master_bit_engine_checker u_scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .fails     (fails)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic in_t make_tick(int cmd_pct, int sda_pct, int scl_pct);
        in_t w;
        w.cmd_valid = ($urandom_range(0, 99) < cmd_pct);
        if ($urandom_range(0, 15) == 0)
            w.func = 3'($urandom_range(int'(FUNC_RECOVER) + 1, 7));
        else
            w.func = 3'($urandom_range(int'(FUNC_START), int'(FUNC_RECOVER)));
        w.wr_data  = 8'($urandom);
        w.send_ack = 1'($urandom);
        w.sda_in   = ($urandom_range(0, 99) < sda_pct);
        w.scl_in   = ($urandom_range(0, 99) < scl_pct);
        return w;
    endfunction

    // Offer one tick word and hold it until the block takes it.
    task automatic send_tick(in_t w);
        while (!tx_steady && $urandom_range(0, 99) < 11)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Stop offering and wait until every predicted word has been popped.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_timing(logic [15:0] hp, logic [15:0] sl);
        drain();
        write_reg(CFG_HALF_PERIOD, hp);
        write_reg(CFG_STRETCH_LIMIT, sl);
        cfg_valid <= 1'b0;
    endtask

    // One command tick, then plain ticks to let it run.
    task automatic run_cmd(logic [2:0] f, logic [7:0] d, logic a,
                           int sda_pct, int scl_pct, int pad);
        in_t w;
        int  n;
        w           = make_tick(0, sda_pct, 100);
        w.cmd_valid = 1'b1;
        w.func      = f;
        w.wr_data   = d;
        w.send_ack  = a;
        send_tick(w);
        for (n = 0; n < pad; n++)
            send_tick(make_tick(0, sda_pct, scl_pct));
    endtask

    // receiver: random pops, plus a long hold-off on request
    initial
    begin
        int k;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_reqs)
            begin
                holds_done++;
                pop <= 1'b0;
                for (k = 1; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            else
            begin
                pop <= (rx_steady || $urandom_range(0, 99) >= 11);
            end
        end
    end

    // watchdog: count cycles in which no handshake completes
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("i2c_master_bit_engine_tb NOT OK");
        $finish;
    end

    initial
    begin
        int s;
        int n;
        push      <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_HALF_PERIOD;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset timing first, then fast timing with short stretch limit
        run_cmd(FUNC_START, 8'h00, 1'b0, 50, 100, 40);
        set_timing(16'd1, 16'd3);
        run_cmd(FUNC_STOP, 8'h00, 1'b0, 50, 100, 30);
        run_cmd(FUNC_WRITE, 8'hFF, 1'b0, 50, 100, 40);
        run_cmd(FUNC_WRITE, 8'h00, 1'b1, 0, 100, 40);
        run_cmd(FUNC_READ, 8'h5A, 1'b1, 50, 100, 40);
        run_cmd(FUNC_READ, 8'hA5, 1'b0, 100, 100, 40);
        run_cmd(3'd5, 8'h00, 1'b0, 50, 100, 3);
        run_cmd(3'd6, 8'h00, 1'b0, 50, 100, 3);
        run_cmd(3'd7, 8'h00, 1'b0, 50, 100, 3);
        // recovery on a free bus, then on SDA held low for all pulses
        run_cmd(FUNC_RECOVER, 8'h00, 1'b0, 100, 100, 10);
        run_cmd(FUNC_RECOVER, 8'h00, 1'b0, 0, 100, 40);
        // a command while busy is dropped
        run_cmd(FUNC_START, 8'h00, 1'b0, 50, 100, 0);
        run_cmd(FUNC_STOP, 8'h00, 1'b0, 50, 100, 30);
        // clock stretching with timeouts
        run_cmd(FUNC_READ, 8'h00, 1'b1, 50, 40, 60);
        set_timing(16'd0, 16'd0);
        run_cmd(FUNC_WRITE, 8'hC3, 1'b0, 50, 50, 50);
        run_cmd(FUNC_START, 8'h00, 1'b0, 50, 100, 10);

        for (s = 0; s < NUM_SEGS; s++)
        begin
            set_timing(16'(seg_hp[s]), 16'(seg_sl[s]));
            tx_steady = (seg_mode[s] != MODE_FREE);
            rx_steady = (seg_mode[s] == MODE_STEADY);
            if (seg_mode[s] == MODE_HOLD)
                hold_reqs++;
            for (n = 0; n < seg_len[s]; n++)
                send_tick(make_tick(seg_cmd[s], seg_sda[s], seg_scl[s]));
            tx_steady = 1'b0;
            rx_steady = 1'b0;
        end

        drain();
        repeat (4) @(posedge clk);
        if (fails == 0)
            $display("i2c_master_bit_engine_tb OK");
        else
            $display("i2c_master_bit_engine_tb NOT OK");
        $finish;
    end

endmodule
